FILE: design/mprl_pkg.sv
// Shared types and constants for the multinomial profile likelihood scorer.
// No dependencies; every other design file refers to it by scoped names.
package mprl_pkg;

  localparam int unsigned IN_W      = 33;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned SCORE_W   = 48;
  localparam int unsigned LOG_FRAC  = 22;
  localparam int unsigned LOG_W     = LOG_FRAC + 6;
  localparam int unsigned LOG_LAT   = LOG_FRAC + 2;
  localparam int unsigned ACC_W     = 64;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [IN_W-1:0] UNIT_P  = 33'h1_0000_0000;
  localparam logic [31:0]     LN2_Q32 = 32'hB172_17F8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TN = 3'd0,
    REG_FP = 3'd1,
    REG_FN = 3'd2,
    REG_TP = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [IN_W-1:0] precision_value;
    logic [IN_W-1:0] recall_value;
  } in_item_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] fp;
    logic [CNT_W-1:0] fn;
    logic [CNT_W-1:0] tp;
  } counts_t;

  typedef struct packed {
    logic p_unit;
    logic r_unit;
  } flags_t;

  typedef struct packed {
    logic [LOG_W-1:0] lgp;
    logic [LOG_W-1:0] lgr;
    logic [LOG_W-1:0] lgpc;
    logic [LOG_W-1:0] lgrc;
    logic [LOG_W-1:0] lgdh;
  } logs_t;

endpackage

FILE: design/mprl_log2.sv
// Pipelined fixed-point log2 over several lanes, with a sideband carried alongside.
// Two normalize stages, then one squaring stage per fraction bit. Uses mprl_pkg.
module mprl_log2 #(
  parameter int unsigned LANES  = 1,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic                                    valid_i,
  input  logic [LANES-1:0][63:0]                  v_i,
  input  logic [SIDE_W-1:0]                       side_i,
  output logic                                    valid_o,
  output logic [LANES-1:0][mprl_pkg::LOG_W-1:0]   log_o,
  output logic [SIDE_W-1:0]                       side_o
);

  localparam int unsigned NS = mprl_pkg::LOG_FRAC;

  logic                   vn1_q;
  logic [SIDE_W-1:0]      sn1_q;
  logic [LANES-1:0][63:0] w_q;
  logic [LANES-1:0]       e5_q;

  logic                      vld_q  [NS+1];
  logic [SIDE_W-1:0]         side_q [NS+1];
  logic [LANES-1:0][31:0]    y_q    [NS+1];
  logic [LANES-1:0][5:0]     k_q    [NS+1];
  logic [LANES-1:0][NS-1:0]  f_q    [NS+1];
  logic [LANES-1:0]          z_q    [NS+1];

  logic [LANES-1:0][4:0]  m_c;
  logic [LANES-1:0][63:0] sh_c;
  logic [LANES-1:0][31:0] yn_c;
  logic [LANES-1:0]       zn_c;

  // Coarse normalize: if the upper half is zero, move the lower half up by 32.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn1_q <= 1'b0;
    end else if (en_i) begin
      vn1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sn1_q <= side_i;
      for (int l = 0; l < LANES; l++) begin
        e5_q[l] <= |v_i[l][63:32];
        w_q[l]  <= (|v_i[l][63:32]) ? v_i[l] : {v_i[l][31:0], 32'd0};
      end
    end
  end

  // Fine normalize: find the leading one in the upper half.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      m_c[l] = '0;
      for (int b = 0; b < 32; b++) begin
        if (w_q[l][32+b]) begin
          m_c[l] = 5'(b);
        end
      end
      sh_c[l] = w_q[l] << (5'd31 - m_c[l]);
      yn_c[l] = sh_c[l][63:32];
      zn_c[l] = ~|w_q[l][63:32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vn1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= sn1_q;
      y_q[0]    <= yn_c;
      f_q[0]    <= '0;
      z_q[0]    <= zn_c;
      for (int l = 0; l < LANES; l++) begin
        k_q[0][l] <= {e5_q[l], m_c[l]};
      end
    end
  end

  // One fraction bit per stage: square, renormalize.
  for (genvar i = 0; i < NS; i++) begin : g_iter
    logic [LANES-1:0][63:0]    sq_c;
    logic [LANES-1:0][31:0]    ny_c;
    logic [LANES-1:0][NS-1:0]  nf_c;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        sq_c[l] = 64'(y_q[i][l]) * 64'(y_q[i][l]);
        ny_c[l] = sq_c[l][63] ? sq_c[l][63:32] : sq_c[l][62:31];
        nf_c[l] = {f_q[i][l][NS-2:0], sq_c[l][63]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[i+1] <= side_q[i];
        y_q[i+1]    <= ny_c;
        f_q[i+1]    <= nf_c;
        k_q[i+1]    <= k_q[i];
        z_q[i+1]    <= z_q[i];
      end
    end
  end

  assign valid_o = vld_q[NS];
  assign side_o  = side_q[NS];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      log_o[l] = z_q[NS][l] ? '0 : {k_q[NS][l], f_q[NS][l]};
    end
  end

endmodule

FILE: design/mprl_null.sv
// Recomputes the observed-likelihood term from the counts after each register write.
// Runs the four logs through its own mprl_log2 and holds busy until done. Uses mprl_pkg.
module mprl_null (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_i,
  input  mprl_pkg::counts_t           counts_i,
  output logic                        busy_o,
  output logic [mprl_pkg::ACC_W-1:0]  null_o
);

  localparam int unsigned ISSUE_N = 4;
  localparam int unsigned MUL_AT  = mprl_pkg::LOG_LAT + ISSUE_N;
  localparam int unsigned DONE    = MUL_AT + 1;
  localparam int unsigned CW      = $clog2(DONE + 1);

  logic                                busy_q;
  logic [CW-1:0]                       cnt_q;
  logic [mprl_pkg::CNT_W+1:0]          n3_c;
  logic [0:0][63:0]                    lg_in_c;
  logic                                issue_c;
  logic                                lg_v;
  logic [0:0][mprl_pkg::LOG_W-1:0]     lg_o;
  logic [1:0]                          lg_tag;
  logic [mprl_pkg::LOG_W-1:0]          lg_q [ISSUE_N];
  logic [2:0][mprl_pkg::CNT_W-1:0]     x_c;
  logic [2:0][mprl_pkg::ACC_W-1:0]     prod_c;
  logic [2:0][mprl_pkg::ACC_W-1:0]     prod_q;
  logic [mprl_pkg::ACC_W-1:0]          null_q;

  assign n3_c    = (mprl_pkg::CNT_W+2)'(counts_i.fp) + (mprl_pkg::CNT_W+2)'(counts_i.fn)
                 + (mprl_pkg::CNT_W+2)'(counts_i.tp);
  assign issue_c = busy_q && (cnt_q < CW'(ISSUE_N));

  // Tag 0 is the total, tags 1..3 the cells.
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    lg_in_c[0] = 64'(n3_c);
      2'd1:    lg_in_c[0] = 64'(counts_i.fp);
      2'd2:    lg_in_c[0] = 64'(counts_i.fn);
      default: lg_in_c[0] = 64'(counts_i.tp);
    endcase
  end

  mprl_log2 #(
    .LANES  (1),
    .SIDE_W (2)
  ) u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (1'b1),
    .valid_i (issue_c),
    .v_i     (lg_in_c),
    .side_i  (cnt_q[1:0]),
    .valid_o (lg_v),
    .log_o   (lg_o),
    .side_o  (lg_tag)
  );

  always_ff @(posedge clk_i) begin
    if (lg_v) begin
      lg_q[lg_tag] <= lg_o[0];
    end
  end

  assign x_c[0] = counts_i.fp;
  assign x_c[1] = counts_i.fn;
  assign x_c[2] = counts_i.tp;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (x_c[c] == '0 || lg_q[c+1] >= lg_q[0]) begin
        prod_c[c] = '0;
      end else begin
        prod_c[c] = mprl_pkg::ACC_W'(x_c[c]) * mprl_pkg::ACC_W'(lg_q[0] - lg_q[c+1]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_q == CW'(MUL_AT)) begin
      prod_q <= prod_c;
    end
  end

  // A write restarts the sequence from the first issue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      null_q <= '0;
    end else if (wr_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CW'(1);
      if (cnt_q == CW'(DONE)) begin
        busy_q <= 1'b0;
        null_q <= prod_q[0] + prod_q[1] + prod_q[2];
      end
    end
  end

  assign busy_o = busy_q;
  assign null_o = null_q;

  a_null_holds_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |=> $stable(null_q))
    else $error("null term changed while not recomputing");

endmodule

FILE: design/mprl_score.sv
// Back half of the item pipeline: log differences, cell products, sums and Q32.16 scaling.
// Six register stages sharing one enable. Uses mprl_pkg.
module mprl_score #(
  parameter int unsigned SCORE_FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  mprl_pkg::logs_t             logs_i,
  input  mprl_pkg::flags_t            flags_i,
  input  mprl_pkg::counts_t           counts_i,
  input  logic [mprl_pkg::ACC_W-1:0]  null_i,
  output logic                        valid_o,
  output mprl_pkg::out_item_t         item_o
);

  localparam int unsigned SHIFT  = 53 - SCORE_FRAC_BITS;
  localparam int unsigned LGD_W  = mprl_pkg::LOG_W + 1;
  localparam int unsigned PROD_W = 96;

  // cell order: tp, fp, fn
  logic [LGD_W-1:0]                   lgd_c;
  logic [2:0][LGD_W-1:0]              num_c;
  logic [2:0][LGD_W-1:0]              mag_c;
  logic [2:0]                         neg_c;
  logic [2:0]                         nz_c;

  logic                               c_v_q, d_v_q, e_v_q, f_v_q, g_v_q, h_v_q;
  logic [2:0][LGD_W-1:0]              c_mag_q;
  logic [2:0]                         c_neg_q, c_nz_q;

  logic [2:0][mprl_pkg::CNT_W-1:0]    x_c;
  logic [2:0][mprl_pkg::ACC_W-1:0]    prod_c;
  logic                               sat_c;
  logic [2:0][mprl_pkg::ACC_W-1:0]    d_prod_q;
  logic [2:0]                         d_neg_q;
  logic                               d_sat_q;

  logic [mprl_pkg::ACC_W-1:0]         pos_c, negs_c;
  logic [mprl_pkg::ACC_W-1:0]         e_pos_q, e_neg_q;
  logic                               e_sat_q;

  logic [mprl_pkg::ACC_W-1:0]         t_c, f_t_q;
  logic                               f_sat_q;

  logic [63:0]                        g_m1_q, g_m2_q;
  logic                               g_sat_q;

  logic [PROD_W-1:0]                  full_c;
  logic [mprl_pkg::SCORE_W-1:0]       sc_c;
  logic                               ovf_c;
  mprl_pkg::out_item_t                item_c, h_item_q;

  // Stage C: log-domain differences per cell.
  always_comb begin
    lgd_c    = LGD_W'(logs_i.lgdh) + (LGD_W'(1) << mprl_pkg::LOG_FRAC);
    num_c[0] = LGD_W'(logs_i.lgp)  + LGD_W'(logs_i.lgr);
    num_c[1] = LGD_W'(logs_i.lgpc) + LGD_W'(logs_i.lgr);
    num_c[2] = LGD_W'(logs_i.lgp)  + LGD_W'(logs_i.lgrc);
    for (int c = 0; c < 3; c++) begin
      neg_c[c] = num_c[c] > lgd_c;
      mag_c[c] = neg_c[c] ? num_c[c] - lgd_c : lgd_c - num_c[c];
    end
    nz_c = {flags_i.r_unit, flags_i.p_unit, 1'b0};
  end

  // Stage D: weight by the counts; a zero numerator with a nonzero count saturates.
  assign x_c = {counts_i.fn, counts_i.fp, counts_i.tp};

  always_comb begin
    sat_c = 1'b0;
    for (int c = 0; c < 3; c++) begin
      prod_c[c] = mprl_pkg::ACC_W'(x_c[c]) * mprl_pkg::ACC_W'(c_mag_q[c]);
      if (c_nz_q[c] && x_c[c] != '0) begin
        sat_c = 1'b1;
      end
    end
  end

  // Stage E: split into positive and negative sums.
  always_comb begin
    pos_c  = '0;
    negs_c = null_i;
    for (int c = 0; c < 3; c++) begin
      if (d_neg_q[c]) begin
        negs_c = negs_c + d_prod_q[c];
      end else begin
        pos_c = pos_c + d_prod_q[c];
      end
    end
  end

  // Stage F: clip rounding noise at zero.
  assign t_c = (e_pos_q > e_neg_q) ? e_pos_q - e_neg_q : '0;

  // Stage H: scale by ln 2 and check the range.
  always_comb begin
    full_c = {32'd0, g_m1_q} + {g_m2_q, 32'd0};
    sc_c   = mprl_pkg::SCORE_W'(full_c >> SHIFT);
    ovf_c  = (full_c >> (SHIFT + mprl_pkg::SCORE_W)) != '0;
    if (g_sat_q || ovf_c) begin
      item_c.score     = '1;
      item_c.saturated = 1'b1;
    end else begin
      item_c.score     = sc_c;
      item_c.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
      g_v_q <= 1'b0;
      h_v_q <= 1'b0;
    end else if (en_i) begin
      c_v_q <= valid_i;
      d_v_q <= c_v_q;
      e_v_q <= d_v_q;
      f_v_q <= e_v_q;
      g_v_q <= f_v_q;
      h_v_q <= g_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_mag_q  <= mag_c;
      c_neg_q  <= neg_c;
      c_nz_q   <= nz_c;
      d_prod_q <= prod_c;
      d_neg_q  <= c_neg_q;
      d_sat_q  <= sat_c;
      e_pos_q  <= pos_c;
      e_neg_q  <= negs_c;
      e_sat_q  <= d_sat_q;
      f_t_q    <= t_c;
      f_sat_q  <= e_sat_q;
      g_m1_q   <= 64'(f_t_q[31:0])  * 64'(mprl_pkg::LN2_Q32);
      g_m2_q   <= 64'(f_t_q[63:32]) * 64'(mprl_pkg::LN2_Q32);
      g_sat_q  <= f_sat_q;
      h_item_q <= item_c;
    end
  end

  assign valid_o = h_v_q;
  assign item_o  = h_item_q;

endmodule

FILE: design/multinomial_pr_profile_loglik.sv
// Multinomial profile likelihood score: top level with counts registers, input stage,
// log bank and output skid. Depends on mprl_pkg, mprl_log2, mprl_null and mprl_score.
//
// Usage:
//   Write the false positive, false negative and true positive counts through the
//   cfg port (index 0 is the true negative count, which is not kept or used for the score).
//   Each write restarts a recompute of the observed-likelihood term; in_stall_o stays
//   high while it runs.
//   Input items (precision, recall, both Q1.32) are taken on in_valid_i with
//   in_stall_o low. One item per cycle is sustained while in_stall_o stays low; the
//   result appears on out_valid_o after the input, log2, scoring and output registers.
//   The log2 pipeline has 24 stages (two normalize, then one squaring per fraction bit).
//   When the receiver stalls, the output register holds and one more result lands in
//   a skid register; the pipeline then freezes and in_stall_o rises until it drains.
//   Reset clears all counts, the cached term and every valid bit.
module multinomial_pr_profile_loglik #(
  parameter int unsigned SCORE_FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  mprl_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output mprl_pkg::out_item_t             out_data_o,
  input  logic                            cfg_we_i,
  input  logic [mprl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mprl_pkg::CNT_W-1:0]      cfg_data_i
);

  localparam int unsigned N_LANES = 5;
  localparam int unsigned LANE_P  = 0;
  localparam int unsigned LANE_R  = 1;
  localparam int unsigned LANE_PC = 2;
  localparam int unsigned LANE_RC = 3;
  localparam int unsigned LANE_D  = 4;

  mprl_pkg::counts_t                 counts_q, counts_d;
  logic                              cfg_hit_c;
  logic                              null_busy;
  logic [mprl_pkg::ACC_W-1:0]        null_val;
  logic                              en;

  logic [mprl_pkg::IN_W-1:0]         p_c, r_c;
  logic [31:0]                       pc_c, rc_c;
  logic [63:0]                       rp_c;
  logic                              a_v_q;
  logic [mprl_pkg::IN_W-1:0]         a_p_q, a_r_q;
  logic [31:0]                       a_pc_q, a_rc_q;
  logic [63:0]                       a_rp_q;
  mprl_pkg::flags_t                  a_flags_q;

  logic [N_LANES-1:0][63:0]                   lane_c;
  logic                                       lg_v;
  logic [N_LANES-1:0][mprl_pkg::LOG_W-1:0]    lg_c;
  logic [1:0]                                 lg_side;
  mprl_pkg::logs_t                            logs_c;
  mprl_pkg::flags_t                           lg_flags;

  logic                              sc_v;
  mprl_pkg::out_item_t               sc_item;

  logic                              out_v_q, out_v_d, skid_v_q, skid_v_d;
  logic                              out_ld, skid_ld, out_src_skid;
  mprl_pkg::out_item_t               out_q, skid_q;

  // Register writes; an index past the list is dropped.
  always_comb begin
    cfg_hit_c = 1'b0;
    counts_d  = counts_q;
    if (cfg_we_i) begin
      unique case (mprl_pkg::cfg_reg_e'(cfg_idx_i))
        mprl_pkg::REG_TN: cfg_hit_c = 1'b1;
        mprl_pkg::REG_FP: begin
          cfg_hit_c   = 1'b1;
          counts_d.fp = cfg_data_i;
        end
        mprl_pkg::REG_FN: begin
          cfg_hit_c   = 1'b1;
          counts_d.fn = cfg_data_i;
        end
        mprl_pkg::REG_TP: begin
          cfg_hit_c   = 1'b1;
          counts_d.tp = cfg_data_i;
        end
        default: cfg_hit_c = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counts_q <= '0;
    end else begin
      counts_q <= counts_d;
    end
  end

  mprl_null u_null (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (cfg_hit_c),
    .counts_i (counts_q),
    .busy_o   (null_busy),
    .null_o   (null_val)
  );

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q || null_busy;

  // Input stage: clamp to [1, 2^32], form complements and R*(1-P).
  always_comb begin
    if (in_data_i.precision_value == '0) begin
      p_c = mprl_pkg::IN_W'(1);
    end else if (in_data_i.precision_value > mprl_pkg::UNIT_P) begin
      p_c = mprl_pkg::UNIT_P;
    end else begin
      p_c = in_data_i.precision_value;
    end
    if (in_data_i.recall_value == '0) begin
      r_c = mprl_pkg::IN_W'(1);
    end else if (in_data_i.recall_value > mprl_pkg::UNIT_P) begin
      r_c = mprl_pkg::UNIT_P;
    end else begin
      r_c = in_data_i.recall_value;
    end
    pc_c = 32'(mprl_pkg::UNIT_P - p_c);
    rc_c = 32'(mprl_pkg::UNIT_P - r_c);
    // recall of exactly one: the product is the complement shifted up
    rp_c = r_c[32] ? {pc_c, 32'd0} : 64'(r_c[31:0]) * 64'(pc_c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= in_valid_i && !in_stall_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_p_q            <= p_c;
      a_r_q            <= r_c;
      a_pc_q           <= pc_c;
      a_rc_q           <= rc_c;
      a_rp_q           <= rp_c;
      a_flags_q.p_unit <= (p_c == mprl_pkg::UNIT_P);
      a_flags_q.r_unit <= (r_c == mprl_pkg::UNIT_P);
    end
  end

  always_comb begin
    lane_c[LANE_P]  = 64'(a_p_q);
    lane_c[LANE_R]  = 64'(a_r_q);
    lane_c[LANE_PC] = 64'(a_pc_q);
    lane_c[LANE_RC] = 64'(a_rc_q);
    lane_c[LANE_D]  = (64'(a_p_q) << 31) + {1'b0, a_rp_q[63:1]};
  end

  mprl_log2 #(
    .LANES  (N_LANES),
    .SIDE_W ($bits(mprl_pkg::flags_t))
  ) u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (a_v_q),
    .v_i     (lane_c),
    .side_i  (a_flags_q),
    .valid_o (lg_v),
    .log_o   (lg_c),
    .side_o  (lg_side)
  );

  always_comb begin
    logs_c.lgp  = lg_c[LANE_P];
    logs_c.lgr  = lg_c[LANE_R];
    logs_c.lgpc = lg_c[LANE_PC];
    logs_c.lgrc = lg_c[LANE_RC];
    logs_c.lgdh = lg_c[LANE_D];
    lg_flags    = mprl_pkg::flags_t'(lg_side);
  end

  mprl_score #(
    .SCORE_FRAC_BITS (SCORE_FRAC_BITS)
  ) u_score (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (lg_v),
    .logs_i   (logs_c),
    .flags_i  (lg_flags),
    .counts_i (counts_q),
    .null_i   (null_val),
    .valid_o  (sc_v),
    .item_o   (sc_item)
  );

  // Output register with one skid entry; the pipeline freezes only when the skid is full.
  always_comb begin
    out_v_d      = out_v_q;
    skid_v_d     = skid_v_q;
    out_ld       = 1'b0;
    skid_ld      = 1'b0;
    out_src_skid = 1'b0;
    if (!skid_v_q) begin
      if (!out_v_q || !out_stall_i) begin
        out_v_d = sc_v;
        out_ld  = 1'b1;
      end else if (sc_v) begin
        skid_v_d = 1'b1;
        skid_ld  = 1'b1;
      end
    end else if (!out_stall_i) begin
      skid_v_d     = 1'b0;
      out_ld       = 1'b1;
      out_src_skid = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_q <= out_src_skid ? skid_q : sc_item;
    end
    if (skid_ld) begin
      skid_q <= sc_item;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry held with empty output register");

  a_write_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit_c |=> in_stall_o)
    else $error("item accepted right after a counts write");

  a_sat_all_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.saturated |-> (out_q.score == '1))
    else $error("saturated result without full-scale score");

endmodule

FILE: dv/tb_multinomial_pr_profile_loglik.sv
// Testbench for multinomial_pr_profile_loglik: predicts each score from the count registers,
// checks every result against it in order, with random idling on both sides. Needs mprl_pkg.
`timescale 1ns / 1ps

module tb_multinomial_pr_profile_loglik;

  localparam int unsigned FRAC       = 16;
  localparam int unsigned DRAIN_CYC  = 40;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [mprl_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd6;
  localparam logic [63:0] UNIT     = 64'h1_0000_0000;
  localparam logic [47:0] SCORE_MAX = '1;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  mprl_pkg::in_item_t  in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  mprl_pkg::out_item_t out_data_o;
  logic                cfg_we_i;
  logic [mprl_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [mprl_pkg::CNT_W-1:0]     cfg_data_i;

  multinomial_pr_profile_loglik #(.SCORE_FRAC_BITS(FRAC)) dut (.*);

  // predictor state
  logic [63:0]         counts [4];
  logic [63:0]         obs_loglik;
  mprl_pkg::out_item_t pending_scores[$];
  int                  errors;
  int                  cycles;
  bit                  long_hold;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] log2_q22(logic [63:0] v);
    int k;
    logic [63:0] y, r;
    if (v == 0) return '0;
    k = 63;
    while (!v[k]) k--;
    y = (v << (63 - k)) >> 32;
    r = 64'(k);
    for (int i = 0; i < mprl_pkg::LOG_FRAC; i++) begin
      y = (y * y) >> 31;
      r = r << 1;
      if ((y >> 32) != 0) begin
        r = r | 64'd1;
        y = y >> 1;
      end
    end
    return r;
  endfunction

  function automatic void refresh_obs_loglik();
    logic [63:0] n3, lgn3, lx;
    n3 = counts[mprl_pkg::REG_FP] + counts[mprl_pkg::REG_FN] + counts[mprl_pkg::REG_TP];
    obs_loglik = '0;
    if (n3 == 0) return;
    lgn3 = log2_q22(n3);
    for (int c = mprl_pkg::REG_FP; c <= mprl_pkg::REG_TP; c++) begin
      if (counts[c] != 0) begin
        lx = log2_q22(counts[c]);
        if (lx < lgn3) obs_loglik += counts[c] * (lgn3 - lx);
      end
    end
  endfunction

  function automatic logic [63:0] clamp_unit(logic [mprl_pkg::IN_W-1:0] v);
    if (v == 0) return 64'd1;
    if (64'(v) > UNIT) return UNIT;
    return 64'(v);
  endfunction

  function automatic mprl_pkg::out_item_t predict_score(mprl_pkg::in_item_t it);
    logic [63:0]         p, r, lgp, lgr, lgpc, lgrc, dh, lgd, pos, neg, t, x, lgnum;
    logic [127:0]        prod;
    logic                sat;
    mprl_pkg::out_item_t res;
    int unsigned         s;
    s = 53 - FRAC;
    p = clamp_unit(it.precision_value);
    r = clamp_unit(it.recall_value);
    lgp = log2_q22(p);
    lgr = log2_q22(r);
    lgpc = (p < UNIT) ? log2_q22(UNIT - p) : 64'd0;
    lgrc = (r < UNIT) ? log2_q22(UNIT - r) : 64'd0;
    dh = (p << 31) + ((r * (UNIT - p)) >> 1);
    lgd = log2_q22(dh) + (64'd1 << mprl_pkg::LOG_FRAC);
    pos = '0;
    neg = obs_loglik;
    sat = 1'b0;
    for (int c = 0; c < 3; c++) begin
      case (c)
        0: begin x = counts[mprl_pkg::REG_TP]; lgnum = lgp + lgr; end
        1: begin
          x = counts[mprl_pkg::REG_FP]; lgnum = lgpc + lgr;
          if (x != 0 && p == UNIT) sat = 1'b1;
        end
        default: begin
          x = counts[mprl_pkg::REG_FN]; lgnum = lgp + lgrc;
          if (x != 0 && r == UNIT) sat = 1'b1;
        end
      endcase
      if (x != 0) begin
        if (lgd >= lgnum) pos += x * (lgd - lgnum);
        else neg += x * (lgnum - lgd);
      end
    end
    t = (pos > neg) ? pos - neg : '0;
    prod = 128'(t) * 128'(mprl_pkg::LN2_Q32);
    if (sat || (prod >> (s + 48)) != 0) begin
      res.score = SCORE_MAX;
      res.saturated = 1'b1;
    end else begin
      res.score = 48'(prod >> s);
      res.saturated = 1'b0;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    mprl_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_scores.size() == 0) begin
        report_mismatch("unexpected item", 64'(out_data_o), 64'd0);
      end else begin
        want = pending_scores.pop_front();
        if (out_data_o.score !== want.score)
          report_mismatch("score", 64'(out_data_o.score), 64'(want.score));
        if (out_data_o.saturated !== want.saturated)
          report_mismatch("saturated", 64'(out_data_o.saturated), 64'(want.saturated));
      end
    end
  end

  // receiver stalls; a requested long hold lets the pipeline fill up
  initial begin
    int run, hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      run = $urandom_range(0, 9) < 3 ? $urandom_range(20, 60) : $urandom_range(1, 6);
      repeat (run) @(negedge clk_i) out_stall_i <= 1'b0;
      if (long_hold) begin
        hold = 300;
        long_hold = 0;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: hold = 0;
          4, 5, 6, 7, 8: hold = $urandom_range(1, 3);
          default: hold = $urandom_range(8, 40);
        endcase
      end
      repeat (hold) @(negedge clk_i) out_stall_i <= 1'b1;
    end
  end

  function automatic int pick_gap();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 0;
      6, 7, 8: return $urandom_range(1, 3);
      default: return $urandom_range(5, 30);
    endcase
  endfunction

  task automatic send_item(logic [mprl_pkg::IN_W-1:0] prec, logic [mprl_pkg::IN_W-1:0] rec,
                           int gap);
    mprl_pkg::in_item_t it;
    it.precision_value = prec;
    it.recall_value = rec;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    pending_scores.push_back(predict_score(it));
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_scores.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [mprl_pkg::CFG_IDX_W-1:0] idx,
                           logic [mprl_pkg::CNT_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx <= mprl_pkg::REG_TP) begin
      counts[idx] = 64'(val);
      refresh_obs_loglik();
    end
  endtask

  task automatic load_counts(logic [31:0] tn, logic [31:0] fp, logic [31:0] fn,
                             logic [31:0] tp);
    drain();
    write_reg(mprl_pkg::REG_TN, tn);
    write_reg(mprl_pkg::REG_FP, fp);
    write_reg(mprl_pkg::REG_FN, fn);
    write_reg(mprl_pkg::REG_TP, tp);
  endtask

  function automatic logic [mprl_pkg::IN_W-1:0] rand_prob();
    case ($urandom_range(0, 7))
      0: return {1'($urandom), 32'($urandom)};
      1: return mprl_pkg::IN_W'(UNIT - 64'($urandom_range(0, 1000)));
      2: return {1'b0, 32'($urandom_range(0, 1000))};
      3: return mprl_pkg::UNIT_P;
      default: return {1'b0, 32'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] rand_count();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'($urandom_range(1, 20));
      2: return 32'($urandom_range(1, 100000));
      3: return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
      default: return 32'($urandom);
    endcase
  endfunction

  task automatic test_reset_counts();
    // all counts zero: score zero whatever the point
    send_item(mprl_pkg::UNIT_P, mprl_pkg::UNIT_P, 0);
    send_item(0, 0, 1);
    send_item('1, {1'($urandom), 32'($urandom)}, 0);
  endtask

  task automatic test_edges();
    load_counts(100, 7, 5, 30);
    send_item(mprl_pkg::UNIT_P, 33'h8000_0000, 0);      // log of zero via precision one
    send_item(33'h8000_0000, mprl_pkg::UNIT_P, 0);      // log of zero via recall one
    send_item(mprl_pkg::UNIT_P, mprl_pkg::UNIT_P, 2);
    send_item(0, 33'h4000_0000, 0);         // clamped up from zero
    send_item('1, 33'h4000_0000, 0);        // clamped down from above one
    send_item(1, 1, 0);
    send_item(33'h1_0000_0001, 0, 3);
    send_item(33'hB000_0000, 33'hA000_0000, 0);
    load_counts(0, 0, 5, 30);
    send_item(mprl_pkg::UNIT_P, 33'h8000_0000, 0);      // precision one is fine without fp
    load_counts(0, 7, 0, 30);
    send_item(33'h8000_0000, mprl_pkg::UNIT_P, 0);      // recall one is fine without fn
    load_counts('1, 0, 0, 0);
    send_item(33'h1234_5678, 33'h8765_4321, 0);
  endtask

  task automatic test_overflow();
    load_counts('1, '1, '1, '1);
    send_item(1, 1, 0);
    send_item(33'h0000_0100, 33'hFFFF_0000, 0);
    send_item(33'hFFFF_FFFF, 33'hFFFF_FFFF, 0);
    // index beyond the map must leave the counts alone
    drain();
    write_reg(REG_UNUSED, 32'h0000_0001);
    send_item(33'h0001_0000, 33'h0001_0000, 0);
  endtask

  task automatic test_backpressure();
    load_counts(50, 3, 9, 40);
    long_hold = 1;
    // start offering once the receiver has begun its long hold
    wait (!long_hold);
    repeat (60) send_item(rand_prob(), rand_prob(), 0);
  endtask

  task automatic test_random_sweep();
    for (int ph = 0; ph < 6; ph++) begin
      load_counts(rand_count(), rand_count(), rand_count(), rand_count());
      repeat (95) send_item(rand_prob(), rand_prob(), pick_gap());
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    errors      = 0;
    long_hold   = 0;
    for (int i = 0; i < 4; i++) counts[i] = '0;
    obs_loglik  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    test_reset_counts();
    test_edges();
    test_overflow();
    test_backpressure();
    test_random_sweep();
    drain();

    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
design/mprl_pkg.sv
design/mprl_log2.sv
design/mprl_null.sv
design/mprl_score.sv
design/multinomial_pr_profile_loglik.sv
dv/tb_multinomial_pr_profile_loglik.sv
